// File: src/complex_arithmetic_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the complex arithmetic unit
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Overlapping implication
`define CAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequence in the cycle after the antecedent
`define CAU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg
// Types, constants and helper functions of the complex arithmetic unit.
// ---------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS = 16;
  // quotient bits produced by the divider chain
  localparam int QB = 33;
  localparam int NW = 64 + FRAC_BITS;
  localparam int CAU_LAT = QB + 5;
  localparam logic [64:0] RND_HALF = (65'd1 << FRAC_BITS) >> 1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_CMP  = 3'd5
  } op_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               is_equal;
    logic               div_zero;
    logic               overflow;
  } out_t;

  // product stage output: signed sums as sign and magnitude
  typedef struct packed {
    logic        valid;
    logic [2:0]  opcode;
    out_t        res;
    logic        neg_re;
    logic [63:0] mag_re;
    logic        neg_im;
    logic [63:0] mag_im;
    logic [63:0] den;
  } prod_t;

  // item travelling down the divider chain
  typedef struct packed {
    logic          valid;
    logic          is_div;
    logic          big_re;
    logic          big_im;
    logic          neg_re;
    logic          neg_im;
    logic [63:0]   rem_re;
    logic [63:0]   rem_im;
    logic [QB-1:0] num_re;
    logic [QB-1:0] num_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    logic [63:0]   den;
    out_t          res;
  } div_t;

  // saturate sign/magnitude to 32 bits; result is {overflow, value}
  function automatic logic [32:0] sat_mag(input logic neg, input logic [64:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 65'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'd0 - mag[31:0]};
    end else begin
      if (mag > 65'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, mag[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] sat_s33(input logic signed [32:0] v);
    logic [32:0] r;
    if (v > 33'sh0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
    else if (v < -33'sh0_8000_0000) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// File: src/complex_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide, conjugate and compare on signed
// fixed point, saturating.
// ---------------------------------------------------------------------------
// One item is taken every cycle; busy stays low. Every opcode takes one path:
// input register, product stages, prep register, divider chain, output
// register; results leave on out_item with a one-cycle out_valid strobe, in
// order. The divider is a chain of 33 cells, each producing one quotient bit
// of both result parts. The receiver cannot stall and must take every strobe.
// ---------------------------------------------------------------------------
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cau_pkg::in_t  in_item,
  output logic          out_valid,
  output cau_pkg::out_t out_item
);
  import cau_pkg::*;

  logic        v0_r;
  in_t         in_r;
  prod_t       prod;
  div_t        prep_r, prep_nxt;
  div_t        chain [0:QB];
  logic        out_valid_r;
  out_t        out_r, out_nxt;

  logic [NW-1:0] n_re, n_im;
  logic [64:0]   mr_re, mr_im;
  logic [32:0]   ms_re, ms_im;
  logic [QB:0]   qr_re, qr_im;
  logic          rnd_re, rnd_im;
  logic [32:0]   ds_re, ds_im;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_item;
  end

  cau_prod u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v0_r),
    .in_item  (in_r),
    .prod     (prod)
  );

  // multiply finishes here; divide gets its numerator split for the chain
  always_comb begin
    mr_re = ({1'b0, prod.mag_re} + RND_HALF) >> FRAC_BITS;
    mr_im = ({1'b0, prod.mag_im} + RND_HALF) >> FRAC_BITS;
    ms_re = sat_mag(prod.neg_re, mr_re);
    ms_im = sat_mag(prod.neg_im, mr_im);
    n_re  = {prod.mag_re, {FRAC_BITS{1'b0}}};
    n_im  = {prod.mag_im, {FRAC_BITS{1'b0}}};

    prep_nxt        = '0;
    prep_nxt.valid  = prod.valid;
    prep_nxt.is_div = (prod.opcode == OP_DIV) && (prod.den != '0);
    prep_nxt.neg_re = prod.neg_re;
    prep_nxt.neg_im = prod.neg_im;
    prep_nxt.den    = prod.den;
    prep_nxt.num_re = n_re[QB-1:0];
    prep_nxt.num_im = n_im[QB-1:0];
    // quotient at or above 2^QB: saturates no matter what
    prep_nxt.big_re = 64'(n_re[NW-1:QB]) >= prod.den;
    prep_nxt.big_im = 64'(n_im[NW-1:QB]) >= prod.den;
    prep_nxt.rem_re = prep_nxt.big_re ? 64'd0 : 64'(n_re[NW-1:QB]);
    prep_nxt.rem_im = prep_nxt.big_im ? 64'd0 : 64'(n_im[NW-1:QB]);
    prep_nxt.res    = prod.res;
    if (prod.opcode == OP_MUL) begin
      prep_nxt.res.res_re   = ms_re[31:0];
      prep_nxt.res.res_im   = ms_im[31:0];
      prep_nxt.res.overflow = ms_re[32] | ms_im[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else begin
      prep_r.valid <= prep_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    prep_r.is_div <= prep_nxt.is_div;
    prep_r.big_re <= prep_nxt.big_re;
    prep_r.big_im <= prep_nxt.big_im;
    prep_r.neg_re <= prep_nxt.neg_re;
    prep_r.neg_im <= prep_nxt.neg_im;
    prep_r.rem_re <= prep_nxt.rem_re;
    prep_r.rem_im <= prep_nxt.rem_im;
    prep_r.num_re <= prep_nxt.num_re;
    prep_r.num_im <= prep_nxt.num_im;
    prep_r.q_re   <= prep_nxt.q_re;
    prep_r.q_im   <= prep_nxt.q_im;
    prep_r.den    <= prep_nxt.den;
    prep_r.res    <= prep_nxt.res;
  end

  assign chain[0] = prep_r;

  for (genvar g = 0; g < QB; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  // round half up on the last remainder, then saturate
  always_comb begin
    rnd_re = {chain[QB].rem_re, 1'b0} >= {1'b0, chain[QB].den};
    rnd_im = {chain[QB].rem_im, 1'b0} >= {1'b0, chain[QB].den};
    qr_re  = {1'b0, chain[QB].q_re} + (QB+1)'(rnd_re);
    qr_im  = {1'b0, chain[QB].q_im} + (QB+1)'(rnd_im);
    ds_re  = sat_mag(chain[QB].neg_re, 65'(qr_re));
    ds_im  = sat_mag(chain[QB].neg_im, 65'(qr_im));
    if (chain[QB].big_re)
      ds_re = {1'b1, chain[QB].neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF};
    if (chain[QB].big_im)
      ds_im = {1'b1, chain[QB].neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF};
    out_nxt = chain[QB].res;
    if (chain[QB].is_div) begin
      out_nxt.res_re   = ds_re[31:0];
      out_nxt.res_im   = ds_im[31:0];
      out_nxt.overflow = ds_re[32] | ds_im[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[QB].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `CAU_ASSERT_IMP(a_latency, start && !busy, ##CAU_LAT out_valid)
  `CAU_ASSERT_IMP(a_divzero, out_valid && out_item.div_zero, out_item.res_re == '0 && out_item.res_im == '0 && !out_item.overflow)
  `CAU_ASSERT_IMP(a_cmp_clean, out_valid && out_item.is_equal, out_item.res_re == '0 && out_item.res_im == '0 && !out_item.div_zero)
  `CAU_ASSERT_NXT(a_no_ghost, !rst_n, !out_valid)

endmodule

// File: src/cau_prod.sv
// ---------------------------------------------------------------------------
// cau_prod
// Two-stage front end: partial products, then signed sums and |b|^2.
// Add, subtract, conjugate and compare finish in the first stage.
// ---------------------------------------------------------------------------
module cau_prod (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  cau_pkg::in_t  in_item,
  output cau_pkg::prod_t prod
);
  import cau_pkg::*;

  logic               v1_r;
  logic [2:0]         op1_r;
  out_t               res1_r, res1_nxt;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r, sr_r, si_r;
  prod_t              prod_r, prod_nxt;

  logic signed [32:0] s_re, s_im;
  logic [32:0]        sat_re, sat_im;
  logic signed [64:0] sum_re, sum_im;
  logic [64:0]        abs_re, abs_im;

  always_comb begin
    res1_nxt = '0;
    s_re = '0;
    s_im = '0;
    case (in_item.opcode)
      OP_ADD: begin
        s_re = {in_item.a_re[31], in_item.a_re} + {in_item.b_re[31], in_item.b_re};
        s_im = {in_item.a_im[31], in_item.a_im} + {in_item.b_im[31], in_item.b_im};
      end
      OP_SUB: begin
        s_re = {in_item.a_re[31], in_item.a_re} - {in_item.b_re[31], in_item.b_re};
        s_im = {in_item.a_im[31], in_item.a_im} - {in_item.b_im[31], in_item.b_im};
      end
      OP_CONJ: begin
        s_re = {in_item.a_re[31], in_item.a_re};
        s_im = 33'sd0 - {in_item.a_im[31], in_item.a_im};
      end
      default: ;
    endcase
    sat_re = sat_s33(s_re);
    sat_im = sat_s33(s_im);
    if (in_item.opcode == OP_ADD || in_item.opcode == OP_SUB ||
        in_item.opcode == OP_CONJ) begin
      res1_nxt.res_re   = sat_re[31:0];
      res1_nxt.res_im   = sat_im[31:0];
      res1_nxt.overflow = sat_re[32] | sat_im[32];
    end
    if (in_item.opcode == OP_CMP)
      res1_nxt.is_equal = (in_item.a_re == in_item.b_re) && (in_item.a_im == in_item.b_im);
    if (in_item.opcode == OP_DIV)
      res1_nxt.div_zero = (in_item.b_re == '0) && (in_item.b_im == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    op1_r  <= in_item.opcode;
    res1_r <= res1_nxt;
    p0_r   <= in_item.a_re * in_item.b_re;
    p1_r   <= in_item.a_im * in_item.b_im;
    p2_r   <= in_item.a_re * in_item.b_im;
    p3_r   <= in_item.a_im * in_item.b_re;
    sr_r   <= in_item.b_re * in_item.b_re;
    si_r   <= in_item.b_im * in_item.b_im;
  end

  // multiply: re = p0 - p1, im = p2 + p3; divide: re = p0 + p1, im = p3 - p2
  always_comb begin
    if (op1_r == OP_MUL) begin
      sum_re = {p0_r[63], p0_r} - {p1_r[63], p1_r};
      sum_im = {p2_r[63], p2_r} + {p3_r[63], p3_r};
    end else begin
      sum_re = {p0_r[63], p0_r} + {p1_r[63], p1_r};
      sum_im = {p3_r[63], p3_r} - {p2_r[63], p2_r};
    end
    abs_re = sum_re[64] ? 65'd0 - sum_re : sum_re;
    abs_im = sum_im[64] ? 65'd0 - sum_im : sum_im;
    prod_nxt        = '0;
    prod_nxt.valid  = v1_r;
    prod_nxt.opcode = op1_r;
    prod_nxt.res    = res1_r;
    prod_nxt.neg_re = sum_re[64];
    prod_nxt.mag_re = abs_re[63:0];
    prod_nxt.neg_im = sum_im[64];
    prod_nxt.mag_im = abs_im[63:0];
    prod_nxt.den    = sr_r + si_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r.valid <= 1'b0;
    end else begin
      prod_r.valid <= prod_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r.opcode <= prod_nxt.opcode;
    prod_r.res    <= prod_nxt.res;
    prod_r.neg_re <= prod_nxt.neg_re;
    prod_r.mag_re <= prod_nxt.mag_re;
    prod_r.neg_im <= prod_nxt.neg_im;
    prod_r.mag_im <= prod_nxt.mag_im;
    prod_r.den    <= prod_nxt.den;
  end

  assign prod = prod_r;

endmodule

// File: src/cau_div_cell.sv
// ---------------------------------------------------------------------------
// cau_div_cell
// One restoring-division step for both result parts; passes the item on.
// ---------------------------------------------------------------------------
module cau_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  cau_pkg::div_t d_in,
  output cau_pkg::div_t d_out
);
  import cau_pkg::*;

  div_t        cell_r, cell_nxt;
  logic [64:0] t_re, t_im;
  logic        ge_re, ge_im;
  logic [64:0] df_re, df_im;

  always_comb begin
    t_re  = {d_in.rem_re, d_in.num_re[QB-1]};
    t_im  = {d_in.rem_im, d_in.num_im[QB-1]};
    ge_re = t_re >= {1'b0, d_in.den};
    ge_im = t_im >= {1'b0, d_in.den};
    df_re = t_re - {1'b0, d_in.den};
    df_im = t_im - {1'b0, d_in.den};
    cell_nxt        = d_in;
    cell_nxt.rem_re = ge_re ? df_re[63:0] : t_re[63:0];
    cell_nxt.rem_im = ge_im ? df_im[63:0] : t_im[63:0];
    cell_nxt.num_re = {d_in.num_re[QB-2:0], 1'b0};
    cell_nxt.num_im = {d_in.num_im[QB-2:0], 1'b0};
    cell_nxt.q_re   = {d_in.q_re[QB-2:0], ge_re};
    cell_nxt.q_im   = {d_in.q_im[QB-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_r.is_div <= cell_nxt.is_div;
    cell_r.big_re <= cell_nxt.big_re;
    cell_r.big_im <= cell_nxt.big_im;
    cell_r.neg_re <= cell_nxt.neg_re;
    cell_r.neg_im <= cell_nxt.neg_im;
    cell_r.rem_re <= cell_nxt.rem_re;
    cell_r.rem_im <= cell_nxt.rem_im;
    cell_r.num_re <= cell_nxt.num_re;
    cell_r.num_im <= cell_nxt.num_im;
    cell_r.q_re   <= cell_nxt.q_re;
    cell_r.q_im   <= cell_nxt.q_im;
    cell_r.den    <= cell_nxt.den;
    cell_r.res    <= cell_nxt.res;
  end

  assign d_out = cell_r;

endmodule
